/* design/lits_pkg.sv */
// Package for the lagged imbalance trade signal core: beat types, register
// indexes, trade codes and arithmetic constants. No dependencies.
`default_nettype none

package lits_pkg;

    // Model and accounting constants
    localparam int NUM_LAGS      = 6;
    localparam int NUM_WEIGHTS   = 6;
    localparam int POINT_VALUE   = 5000;
    localparam int FEE_PER_TRADE = 100;

    // Taps that carry a weight; lags past the last weight count as zero
    localparam int NUM_TAPS  = (NUM_LAGS < NUM_WEIGHTS) ? NUM_LAGS : NUM_WEIGHTS;
    localparam int TAP_IDX_W = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int HIST_IDX_W = (NUM_LAGS > 1) ? $clog2(NUM_LAGS) : 1;
    localparam int WT_IDX_W  = $clog2(NUM_WEIGHTS);
    localparam int SEEN_W    = $clog2(NUM_LAGS + 1);

    // Exact sum of intercept and all tap products
    localparam int ACC_W = 64 + $clog2(NUM_TAPS + 1) + 1;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Trade thresholds, Q16.16
    localparam int THRESHOLD_Q16 = 15 * 65536;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERCEPT    = 3'd0,
        REG_WEIGHT_FIRST = 3'd1,
        REG_MAX_POSITION = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_BUY  = 2'd1,
        ACT_SELL = 2'd2
    } t_action;

    typedef struct packed {
        logic signed [31:0] imbalance;
        logic [30:0]        best_bid;
        logic [30:0]        best_ask;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         trade_action;
        logic [30:0]        trade_price;
        logic signed [15:0] net_position;
        logic signed [47:0] prediction;
        logic signed [63:0] profit_and_loss;
    } t_out_beat;

endpackage : lits_pkg

`default_nettype wire

/* design/lagged_imbalance_trade_signal_core.sv */
// Top level of the lagged imbalance trade signal core: tap history, one shared
// multiplier under a sequencer, trade decision and PnL marking.
// Depends on lits_pkg.
//
//  Channel  | Direction | Handshake              | Beat
//  ---------+-----------+------------------------+--------------------------------
//  input    | in        | i_in_valid/o_in_stall  | lits_pkg::t_in_beat
//  output   | out       | o_out_valid/i_out_stall| lits_pkg::t_out_beat
//  config   | in        | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// One input beat occupies the block until its result is loaded; once the
// history is full it runs through the single 33x33 multiplier, which takes
// one tap per cycle and then the mark and the two halves of the point-value
// scaling. During warm-up the taps are skipped.
// Reset (synchronous, active low) clears the history, counters, position and
// totals, the weights and the output valid. A stalled output beat holds in the
// output register; the core waits for it to leave before finishing the next.
`default_nettype none

module lagged_imbalance_trade_signal_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input beats
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire lits_pkg::t_in_beat            i_in_data,
    // output beats
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output lits_pkg::t_out_beat                o_out_data,
    // configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic [lits_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lits_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lits_pkg::*;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,  // wait for an input beat
        S_MUL    = 9'b000000010,  // issue one tap product, add the previous one
        S_LAST   = 9'b000000100,  // add the final tap product
        S_DECIDE = 9'b000001000,  // threshold test, position and totals
        S_MARK   = 9'b000010000,  // price times open position
        S_DIFF   = 9'b000100000,  // cash difference in ticks
        S_PVLO   = 9'b001000000,  // point value times low half
        S_PVHI   = 9'b010000000,  // point value times high half
        S_FIN    = 9'b100000000   // assemble PnL, load output register
    } t_state;

    t_state r_state, n_state;

    // Configuration
    logic signed [31:0] r_icpt, n_icpt;
    logic signed [31:0] r_wt   [NUM_WEIGHTS];
    logic signed [31:0] n_wt   [NUM_WEIGHTS];
    logic [14:0]        r_maxpos, n_maxpos;

    // History and per-beat work registers
    logic signed [31:0]  r_hist [NUM_LAGS];
    logic signed [31:0]  n_hist [NUM_LAGS];
    logic [SEEN_W-1:0]   r_seen, n_seen;
    logic [TAP_IDX_W-1:0] r_idx, n_idx;
    logic [30:0]         r_bid, n_bid;
    logic [30:0]         r_ask, n_ask;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic [63:0]         r_diff, n_diff;
    logic [63:0]         r_pnl, n_pnl;
    logic [1:0]          r_action, n_action;
    logic [30:0]         r_price, n_price;
    logic signed [47:0]  r_pred, n_pred;

    // Running book
    logic signed [15:0]  r_pos, n_pos;
    logic [63:0]         r_bought, n_bought;
    logic [63:0]         r_sold, n_sold;
    logic [47:0]         r_fee, n_fee;

    // Output register
    logic                r_out_vld, n_out_vld;
    t_out_beat           r_out, n_out;

    // Shared multiplier operands
    logic signed [MUL_W-1:0] mul_a, mul_b;

    // Decision helpers
    logic                in_take;
    logic                out_free;
    logic                warm;
    logic                buy, sell;
    logic                acc_fits;
    logic [15:0]         pos_abs;
    logic [WT_IDX_W-1:0] wt_sel;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || !i_out_stall;
    assign warm     = (r_seen >= SEEN_W'(NUM_LAGS - 1));

    // Exact-sum threshold tests
    assign buy  = (r_acc >= $signed(ACC_W'(THRESHOLD_Q16)));
    assign sell = (r_acc <= -$signed(ACC_W'(THRESHOLD_Q16)));

    // The sum fits in 48 bits when all bits from bit 47 upward agree
    assign acc_fits = (&r_acc[ACC_W-1:47]) || !(|r_acc[ACC_W-1:47]);

    assign pos_abs = r_pos[15] ? 16'(-r_pos) : r_pos;
    assign wt_sel  = WT_IDX_W'(i_cfg_idx - REG_WEIGHT_FIRST);

    // Operand selection for the one multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MUL: begin
                mul_a = MUL_W'(r_wt[WT_IDX_W'(r_idx)]);
                mul_b = MUL_W'(r_hist[HIST_IDX_W'(r_idx)]);
            end
            S_MARK: begin
                mul_a = r_pos[15] ? {2'b00, r_ask} : {2'b00, r_bid};
                mul_b = {17'd0, pos_abs};
            end
            S_PVLO: begin
                mul_a = MUL_W'(POINT_VALUE);
                mul_b = {1'b0, r_diff[31:0]};
            end
            S_PVHI: begin
                mul_a = MUL_W'(POINT_VALUE);
                mul_b = {1'b0, r_diff[63:32]};
            end
            S_IDLE, S_LAST, S_DECIDE, S_DIFF, S_FIN: begin
                mul_a = '0;
                mul_b = '0;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_icpt    = r_icpt;
        n_wt      = r_wt;
        n_maxpos  = r_maxpos;
        n_hist    = r_hist;
        n_seen    = r_seen;
        n_idx     = r_idx;
        n_bid     = r_bid;
        n_ask     = r_ask;
        n_acc     = r_acc;
        n_prod    = r_prod;
        n_diff    = r_diff;
        n_pnl     = r_pnl;
        n_action  = r_action;
        n_price   = r_price;
        n_pred    = r_pred;
        n_pos     = r_pos;
        n_bought  = r_bought;
        n_sold    = r_sold;
        n_fee     = r_fee;
        n_out     = r_out;
        n_out_vld = r_out_vld;

        // Drop the output beat once taken
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        // The user must write registers only while idle (the block does not enforce it); unknown indexes are ignored
        if (i_cfg_we) begin
            priority if (i_cfg_idx == REG_INTERCEPT) begin
                n_icpt = $signed(i_cfg_data);
            end else if (i_cfg_idx >= REG_WEIGHT_FIRST &&
                         i_cfg_idx < CFG_IDX_W'(REG_WEIGHT_FIRST + NUM_WEIGHTS)) begin
                n_wt[wt_sel] = $signed(i_cfg_data);
            end else if (i_cfg_idx == REG_MAX_POSITION) begin
                n_maxpos = i_cfg_data[14:0];
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    // Advance the history and start the sum
                    for (int k = NUM_LAGS - 1; k > 0; k--) begin
                        n_hist[k] = r_hist[k-1];
                    end
                    n_hist[0] = i_in_data.imbalance;
                    if (r_seen < SEEN_W'(NUM_LAGS)) begin
                        n_seen = r_seen + 1'b1;
                    end
                    n_bid = i_in_data.best_bid;
                    n_ask = i_in_data.best_ask;
                    n_idx = '0;
                    if (warm) begin
                        n_acc   = ACC_W'(r_icpt);
                        n_state = S_MUL;
                    end else begin
                        n_acc   = '0;
                        n_state = S_DECIDE;
                    end
                end
            end
            S_MUL: begin
                n_prod = mul_a * mul_b;
                if (r_idx != '0) begin
                    n_acc = r_acc + ACC_W'(r_prod);
                end
                if (r_idx == TAP_IDX_W'(NUM_TAPS - 1)) begin
                    n_state = S_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LAST: begin
                n_acc   = r_acc + ACC_W'(r_prod);
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (acc_fits) begin
                    n_pred = r_acc[47:0];
                end else if (r_acc[ACC_W-1]) begin
                    n_pred = {1'b1, 47'd0};
                end else begin
                    n_pred = {1'b0, {47{1'b1}}};
                end
                n_action = ACT_NONE;
                n_price  = '0;
                if (buy && (r_pos < $signed({1'b0, r_maxpos}))) begin
                    n_pos    = r_pos + 16'sd1;
                    n_bought = r_bought + 64'(r_ask);
                    n_fee    = r_fee + 48'(FEE_PER_TRADE);
                    n_action = ACT_BUY;
                    n_price  = r_ask;
                end else if (sell && (r_pos > -$signed({1'b0, r_maxpos}))) begin
                    n_pos    = r_pos - 16'sd1;
                    n_sold   = r_sold + 64'(r_bid);
                    n_fee    = r_fee + 48'(FEE_PER_TRADE);
                    n_action = ACT_SELL;
                    n_price  = r_bid;
                end
                n_state = S_MARK;
            end
            S_MARK: begin
                // Long marks at the bid, short at the ask; flat gives zero
                n_prod  = mul_a * mul_b;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                if (r_pos[15]) begin
                    n_diff = r_sold - r_bought - r_prod[63:0];
                end else begin
                    n_diff = r_sold - r_bought + r_prod[63:0];
                end
                n_state = S_PVLO;
            end
            S_PVLO: begin
                n_prod  = mul_a * mul_b;
                n_state = S_PVHI;
            end
            S_PVHI: begin
                n_pnl   = r_prod[63:0];
                n_prod  = mul_a * mul_b;
                n_state = S_FIN;
            end
            S_FIN: begin
                // Hold here until the output register is free
                if (out_free) begin
                    n_out.trade_action     = r_action;
                    n_out.trade_price      = r_price;
                    n_out.net_position     = r_pos;
                    n_out.prediction       = r_pred;
                    n_out.profit_and_loss  = r_pnl + {r_prod[31:0], 32'd0}
                                             - {16'd0, r_fee};
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_icpt    <= '0;
            r_wt      <= '{default: '0};
            r_maxpos  <= '0;
            r_hist    <= '{default: '0};
            r_seen    <= '0;
            r_idx     <= '0;
            r_pos     <= '0;
            r_bought  <= '0;
            r_sold    <= '0;
            r_fee     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_icpt    <= n_icpt;
            r_wt      <= n_wt;
            r_maxpos  <= n_maxpos;
            r_hist    <= n_hist;
            r_seen    <= n_seen;
            r_idx     <= n_idx;
            r_pos     <= n_pos;
            r_bought  <= n_bought;
            r_sold    <= n_sold;
            r_fee     <= n_fee;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_bid    <= n_bid;
        r_ask    <= n_ask;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
        r_diff   <= n_diff;
        r_pnl    <= n_pnl;
        r_action <= n_action;
        r_price  <= n_price;
        r_pred   <= n_pred;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule : lagged_imbalance_trade_signal_core

`default_nettype wire

/* tb/sv/tb_lagged_imbalance_trade_signal_core.sv */
// Self-checking bench for lagged_imbalance_trade_signal_core: bursty book updates in,
// randomly stalled trade beats out, each checked against an in-bench signal/PnL predictor.
// Depends on lits_pkg and the core RTL only.
module tb_lagged_imbalance_trade_signal_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lits_pkg::*;

    localparam int RANDOM_PER_PHASE = 235;
    localparam int NUM_PHASES       = 8;
    // Longer than any single beat, with a generous margin
    localparam int SETTLE_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES  = 120;
    localparam int IDLE_LIMIT       = 4000;

    localparam logic signed [71:0] PRED_MAX = 72'sd140737488355327;
    localparam logic signed [71:0] PRED_MIN = -72'sd140737488355328;

    // Clock, reset and block pins
    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    t_in_beat  in_data  = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_data;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always #4 clk = ~clk;

    lagged_imbalance_trade_signal_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // Book updates waiting to be driven, and trade beats the predictor expects
    t_in_beat  pending_updates[$];
    t_out_beat expected_trades[$];

    // Shadow of the model registers, kept in step with every write
    logic signed [31:0] intercept_q = '0;
    logic signed [31:0] weight_q [NUM_WEIGHTS] = '{default: '0};
    int                 pos_limit = 0;
    logic [31:0]        plan_weight [NUM_WEIGHTS];

    // Predictor state: lag history, warm-up count, position and running totals
    logic signed [31:0] lag_samples [NUM_LAGS] = '{default: '0};
    int                 samples_seen = 0;
    int                 pos_units    = 0;
    logic [63:0]        bought_sum   = '0;
    logic [63:0]        sold_sum     = '0;
    logic [47:0]        fee_sum      = '0;

    int mismatches   = 0;
    int results_seen = 0;
    int buys         = 0;
    int sells        = 0;
    int pos_high     = 0;
    int pos_low      = 0;
    int saturations  = 0;
    int settings     = 0;

    // Advance the lag history, form the prediction, decide the trade and mark the book.
    function automatic t_out_beat predict_trade(input t_in_beat beat);
        t_out_beat          res;
        logic signed [71:0] acc;
        logic signed [63:0] prod;
        logic [63:0]        mark_long;
        logic [63:0]        mark_short;
        logic [63:0]        diff;
        logic               go_long;
        logic               go_short;
        res        = '0;
        go_long    = 1'b0;
        go_short   = 1'b0;
        mark_long  = '0;
        mark_short = '0;
        for (int k = NUM_LAGS - 1; k > 0; k--)
            lag_samples[k] = lag_samples[k-1];
        lag_samples[0] = beat.imbalance;
        if (samples_seen < NUM_LAGS)
            samples_seen++;

        // Until the history is full the prediction stays zero and never trades
        if (samples_seen >= NUM_LAGS) begin
            acc = intercept_q;
            for (int k = 0; k < NUM_TAPS; k++) begin
                prod = lag_samples[k] * weight_q[k];
                acc  = acc + prod;
            end
            // Thresholds test the exact sum; only the reported value saturates
            go_long  = (acc >= THRESHOLD_Q16);
            go_short = (acc <= -THRESHOLD_Q16);
            if (acc > PRED_MAX) begin
                res.prediction = PRED_MAX[47:0];
                saturations++;
            end else if (acc < PRED_MIN) begin
                res.prediction = PRED_MIN[47:0];
                saturations++;
            end else begin
                res.prediction = acc[47:0];
            end
        end

        res.trade_action = ACT_NONE;
        if (go_long && pos_units < pos_limit) begin
            pos_units++;
            bought_sum        = bought_sum + 64'(beat.best_ask);
            fee_sum           = fee_sum + 48'(FEE_PER_TRADE);
            res.trade_action  = ACT_BUY;
            res.trade_price   = beat.best_ask;
            buys++;
        end else if (go_short && pos_units > -pos_limit) begin
            pos_units--;
            sold_sum          = sold_sum + 64'(beat.best_bid);
            fee_sum           = fee_sum + 48'(FEE_PER_TRADE);
            res.trade_action  = ACT_SELL;
            res.trade_price   = beat.best_bid;
            sells++;
        end

        // Mark a long position at the bid and a short one at the ask
        if (pos_units > 0)
            mark_long = 64'(beat.best_bid) * 64'(pos_units);
        else if (pos_units < 0)
            mark_short = 64'(beat.best_ask) * 64'(-pos_units);
        diff = sold_sum + mark_long - bought_sum - mark_short;
        res.profit_and_loss = diff * 64'(POINT_VALUE) - 64'(fee_sum);
        res.net_position    = 16'(pos_units);
        if (pos_units > pos_high) pos_high = pos_units;
        if (pos_units < pos_low)  pos_low  = pos_units;
        return res;
    endfunction

    function automatic t_in_beat book(input logic [31:0] imb, input logic [30:0] bid,
                                      input logic [30:0] ask);
        t_in_beat b;
        b.imbalance = imb;
        b.best_bid  = bid;
        b.best_ask  = ask;
        return b;
    endfunction

    function automatic logic [31:0] rand_span(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // Random update: span zero means the full 32-bit imbalance range
    function automatic t_in_beat random_update(input int imb_span);
        t_in_beat    b;
        int unsigned mid;
        b.imbalance = (imb_span == 0) ? $urandom : rand_span(imb_span);
        case ($urandom_range(0, 7))
            0, 1: begin
                b.best_bid = 31'($urandom);
                b.best_ask = 31'($urandom);
            end
            2: begin
                // tiny, zero or crossed prices
                b.best_bid = 31'($urandom_range(0, 50));
                b.best_ask = 31'($urandom_range(0, 50));
            end
            default: begin
                mid        = $urandom_range(1000, 200000);
                b.best_bid = 31'(mid);
                b.best_ask = 31'(mid + $urandom_range(1, 4));
            end
        endcase
        return b;
    endfunction

    // Driver: hold each beat until taken, release beats in bursts with gaps between
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk) begin : drive_updates
        t_in_beat next_beat;
        logic     next_valid;
        if (!rst_n) begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            next_valid = in_valid;
            next_beat  = in_data;
            if (in_valid && !in_stall)
                expected_trades.push_back(predict_trade(in_data));
            // Advance only when the slot is empty or its beat has just gone
            if (!in_valid || !in_stall) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_updates.size() > 0) begin
                    next_beat  = pending_updates.pop_front();
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        if ($urandom_range(0, 7) == 0) begin
                            // long run with no idling at all
                            burst_left = $urandom_range(100, 300);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 30);
                            gap_left   = ($urandom_range(0, 3) == 0) ?
                                         $urandom_range(4, 24) : $urandom_range(0, 3);
                        end
                    end
                end
            end
            in_valid <= next_valid;
            in_data  <= next_beat;
        end
    end

    // Monitor: check each trade beat against the oldest expectation, then pick the stall
    int hold_left  = 0;
    int stall_mode = 0;
    int mode_left  = 0;

    always @(posedge clk) begin : check_trades
        t_out_beat want;
        logic      stall_next;
        logic      bad;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (expected_trades.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected trade beat: act=%0d px=%0d pos=%0d",
                                 $realtime, out_data.trade_action, out_data.trade_price,
                                 out_data.net_position);
                end else begin
                    want = expected_trades.pop_front();
                    bad  = (out_data.trade_action     !== want.trade_action)
                        || (out_data.trade_price      !== want.trade_price)
                        || (out_data.net_position     !== want.net_position)
                        || (out_data.prediction       !== want.prediction)
                        || (out_data.profit_and_loss  !== want.profit_and_loss);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] beat %0d mismatch: act %0d/%0d px %0d/%0d ",
                                      "pos %0d/%0d pred %0d/%0d pnl %0d/%0d (exp/got)"},
                                     $realtime, results_seen,
                                     want.trade_action, out_data.trade_action,
                                     want.trade_price, out_data.trade_price,
                                     want.net_position, out_data.net_position,
                                     want.prediction, out_data.prediction,
                                     want.profit_and_loss, out_data.profit_and_loss);
                    end
                end
                // Twice in the run, hold off long enough for the core to back up
                if (results_seen == 400 || results_seen == 1300)
                    hold_left = HOLD_OFF_CYCLES;
            end

            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else begin
                if (mode_left <= 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(50, 200);
                end
                mode_left--;
                case (stall_mode)
                    0:       stall_next = 1'b0;
                    1:       stall_next = ($urandom_range(0, 9) < 3);
                    2:       stall_next = ($urandom_range(0, 9) < 8);
                    default: stall_next = ~out_stall;
                endcase
            end
            out_stall <= stall_next;
        end
    end

    // Watchdog: any stretch with no beat and no write beyond the limit ends the run
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d trades outstanding",
                         idle_cycles, expected_trades.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // Wait until every update has gone in and every trade beat has come out
    task automatic drain();
        while (pending_updates.size() != 0 || in_valid || expected_trades.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        if (idx == REG_INTERCEPT)
            intercept_q = val;
        else if (idx == REG_MAX_POSITION)
            pos_limit = int'(val[14:0]);
        else
            weight_q[idx - REG_WEIGHT_FIRST] = val;
    endtask

    // Write every register: intercept, the planned weights and the position limit
    task automatic program_model(input logic [31:0] icpt, input int limit);
        write_reg(REG_INTERCEPT, icpt);
        for (int k = 0; k < NUM_WEIGHTS; k++)
            write_reg(CFG_IDX_W'(REG_WEIGHT_FIRST + k), plan_weight[k]);
        write_reg(REG_MAX_POSITION, 32'(limit));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings++;
    endtask

    initial begin
        logic [31:0] icpt;
        int          span;
        int          limit;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Warm-up under reset settings, with the field extremes
        pending_updates.push_back(book(32'h8000_0000, 31'd0, 31'h7FFF_FFFF));
        pending_updates.push_back(book(32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0));
        pending_updates.push_back(book(32'h0000_0000, 31'd100, 31'd100));
        pending_updates.push_back(book(32'hFFFF_FFFF, 31'd5, 31'd3));
        pending_updates.push_back(book(32'h0000_0001, 31'd1000, 31'd1001));
        pending_updates.push_back(book(32'h5555_AAAA, 31'h2AAA_5555, 31'h5555_2AAA));
        drain();

        // Intercept alone sits exactly on, then just inside, each threshold
        foreach (plan_weight[k]) plan_weight[k] = '0;
        program_model(THRESHOLD_Q16, 1);
        repeat (3) pending_updates.push_back(book(32'd7, 31'd5000, 31'd5002));
        drain();
        program_model(-THRESHOLD_Q16, 1);
        repeat (3) pending_updates.push_back(book(32'd7, 31'd5010, 31'd5011));
        drain();
        program_model(THRESHOLD_Q16 - 1, 1);
        pending_updates.push_back(book(32'd7, 31'd4990, 31'd4991));
        drain();
        program_model(-THRESHOLD_Q16 + 1, 1);
        pending_updates.push_back(book(32'd7, 31'd4990, 31'd4991));
        drain();

        // Most negative weights on most negative samples: far beyond 48 bits, buy side
        foreach (plan_weight[k]) plan_weight[k] = 32'h8000_0000;
        program_model(32'h7FFF_FFFF, 32767);
        repeat (3) pending_updates.push_back(book(32'h8000_0000, 31'd70000, 31'd70003));
        drain();
        // ...and the mirror image, saturating low and selling
        foreach (plan_weight[k]) plan_weight[k] = 32'h7FFF_FFFF;
        program_model(32'h8000_0000, 32767);
        repeat (3) pending_updates.push_back(book(32'h8000_0000, 31'd69000, 31'd69002));
        drain();

        // One tap of 1.0 on the largest sample lands exactly on, then just past, 48 bits
        foreach (plan_weight[k]) plan_weight[k] = '0;
        plan_weight[0] = 32'h0001_0000;
        program_model(32'h0000_FFFF, 32767);
        pending_updates.push_back(book(32'h7FFF_FFFF, 31'd300, 31'd301));
        drain();
        program_model(32'h0001_0000, 32767);
        pending_updates.push_back(book(32'h7FFF_FFFF, 31'd300, 31'd301));
        drain();

        // Random phases, each under a new setting; the pause at each boundary
        // lets every trade beat drain before the registers move
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                1, 5: begin
                    icpt = $urandom;
                    foreach (plan_weight[k]) plan_weight[k] = $urandom;
                    span  = 0;
                    limit = (phase == 1) ? $urandom_range(0, 32767) : 1;
                end
                3, 6: begin
                    // bias the intercept just around a threshold, let it run long
                    icpt = 14 * 65536 + $urandom_range(0, 131072);
                    if (phase == 6) icpt = -icpt;
                    foreach (plan_weight[k]) plan_weight[k] = rand_span(4096);
                    span  = 40;
                    limit = 32767;
                end
                4: begin
                    icpt = '0;
                    foreach (plan_weight[k]) plan_weight[k] = rand_span(4096);
                    span  = 3000;
                    limit = 10;
                end
                default: begin
                    icpt = rand_span(1 << 20);
                    foreach (plan_weight[k]) plan_weight[k] = rand_span(65536);
                    span  = 20;
                    limit = (phase == 0) ? 3 : (phase == 2) ? 0 : 5;
                end
            endcase
            program_model(icpt, limit);
            repeat (RANDOM_PER_PHASE) pending_updates.push_back(random_update(span));
            drain();
        end

        $display("covered %0d book updates over %0d settings: %0d buys, %0d sells,",
                 results_seen, settings, buys, sells);
        $display("position from %0d to %0d, %0d saturated predictions, %0d mismatches",
                 pos_low, pos_high, saturations, mismatches);
        if (mismatches == 0 && expected_trades.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
